FILE: rtl/core/ffmt_pkg.sv
// Shared types and constants for the first-fit max tree allocator.
// No dependencies; imported by the walker and the top level.
package ffmt_pkg;

  localparam int SLOT_W = 10;   // slot field width on the ports
  localparam int AMT_W  = 30;   // amount field width on the ports
  localparam int CMP_W  = 32;   // common width for amount versus node compares

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_ALLOC = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } ffmt_result_t;

endpackage

FILE: rtl/core/ffmt_tree_ram.sv
// Row memory for the max tree: one row holds a sibling pair of nodes.
// One write port, one read port, registered read data. No dependencies.
module ffmt_tree_ram #(
  parameter int ROWS = 1024,
  parameter int DW   = 60
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [$clog2(ROWS)-1:0] waddr,
  input  logic [DW-1:0]           wdata,
  input  logic [$clog2(ROWS)-1:0] raddr,
  output logic [DW-1:0]           rdata
);

  logic [DW-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/ffmt_walker.sv
// Sequencer for the max tree: clearing sweep, descent and path refresh.
// Depends on ffmt_pkg; drives the ports of ffmt_tree_ram.
module ffmt_walker #(
  parameter int LEAVES     = 1024,
  parameter int VALUE_BITS = 30
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic [ffmt_pkg::SLOT_W-1:0]       slot_index,
  input  logic [ffmt_pkg::AMT_W-1:0]        amount,
  output logic                              mem_we,
  output logic [$clog2(LEAVES)-1:0]         mem_waddr,
  output logic [2*VALUE_BITS-1:0]           mem_wdata,
  output logic [$clog2(LEAVES)-1:0]         mem_raddr,
  input  logic [2*VALUE_BITS-1:0]           mem_rdata,
  output logic                              res_valid,
  input  logic                              res_ready,
  output ffmt_pkg::ffmt_result_t            res
);
  import ffmt_pkg::*;

  localparam int LVL    = $clog2(LEAVES);
  localparam int ROW_W  = LVL;
  localparam int NODE_W = LVL + 1;
  localparam int VB     = VALUE_BITS;
  localparam int SW     = ((LVL > SLOT_W) ? LVL : SLOT_W) + 1;
  localparam logic [CMP_W-1:0] VMAX = CMP_W'((64'd1 << VALUE_BITS) - 64'd1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ROOT,
    S_DESC,
    S_ASC,
    S_EMIT
  } state_t;

  state_t            state;
  logic [ROW_W-1:0]  clr_row;
  logic              is_req;
  logic [AMT_W-1:0]  amt;
  logic [NODE_W-1:0] node;
  logic [VB-1:0]     cur_val;

  logic [VB-1:0]     lo, hi, sib, leaf_val, up_val;
  logic [SW-1:0]     slot_wide;
  logic              slot_ok;
  logic [NODE_W-1:0] leaf_node, child;
  logic              go_left;
  logic [VB-1:0]     load_val;

  assign lo        = mem_rdata[VB-1:0];
  assign hi        = mem_rdata[2*VB-1:VB];
  assign slot_wide = SW'(slot_index);
  assign slot_ok   = (slot_wide < SW'(LEAVES));
  assign leaf_node = {1'b1, slot_wide[LVL-1:0]};
  assign load_val  = (CMP_W'(amount) > VMAX) ? VB'(VMAX) : VB'(amount);
  assign go_left   = (CMP_W'(lo) >= CMP_W'(amt));
  assign child     = {node[LVL-1:0], ~go_left};
  assign leaf_val  = go_left ? lo : hi;
  assign sib       = node[0] ? lo : hi;
  assign up_val    = (cur_val > sib) ? cur_val : sib;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_row;
      end
      S_IDLE: begin
        // a request checks the root first; a load needs the row of its leaf
        mem_raddr = (req_type == REQ_ALLOC) ? ROW_W'(0) : leaf_node[LVL:1];
      end
      S_ROOT: begin
        mem_raddr = ROW_W'(1);
      end
      S_DESC: begin
        // leaf reached: reread the row that holds the leaf for the refresh
        mem_raddr = child[LVL] ? ROW_W'(node) : ROW_W'(child);
      end
      S_ASC: begin
        mem_we    = 1'b1;
        mem_waddr = ROW_W'(node >> 1);
        mem_wdata = node[0] ? {cur_val, lo} : {hi, cur_val};
        mem_raddr = ROW_W'(node >> 2);
      end
      S_EMIT: begin
        mem_raddr = '0;
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_row <= '0;
      is_req  <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_row <= clr_row + ROW_W'(1);
          if (clr_row == ROW_W'(LEAVES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (req_type == REQ_ALLOC) begin
              is_req <= 1'b1;
              amt    <= amount;
              state  <= S_ROOT;
            end else if (slot_ok) begin
              is_req  <= 1'b0;
              node    <= leaf_node;
              cur_val <= load_val;
              state   <= S_ASC;
            end
          end
        end
        S_ROOT: begin
          if (CMP_W'(hi) < CMP_W'(amt)) begin
            res.found <= 1'b0;
            res.slot  <= '0;
            state     <= S_EMIT;
          end else begin
            node  <= NODE_W'(1);
            state <= S_DESC;
          end
        end
        S_DESC: begin
          node <= child;
          if (child[LVL]) begin
            cur_val   <= leaf_val - VB'(amt);
            res.found <= 1'b1;
            res.slot  <= SLOT_W'(child[LVL-1:0]);
            state     <= S_ASC;
          end
        end
        S_ASC: begin
          if (node == NODE_W'(1)) begin
            state <= is_req ? S_EMIT : S_IDLE;
          end else begin
            node    <= node >> 1;
            cur_val <= up_val;
          end
        end
        S_EMIT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/first_fit_max_tree_allocator_core.sv
// First-fit allocator over a binary max tree kept in a row memory.
// Depends on ffmt_pkg, ffmt_walker and ffmt_tree_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) carries req_type, slot_index, amount.
//   A load transaction (req_type = 0) writes one slot capacity, saturated to
//   VALUE_BITS, and produces no result; a slot index of LEAVES or more is dropped.
//   An allocation transaction (req_type = 1) produces one result on the
//   output channel (out_valid/out_ready): found and the leftmost slot whose
//   capacity covers amount; that capacity is reduced by amount.
// Sequence:
//   A load occupies the block for its path refresh; an allocation for a root
//   read, descent reads down to a leaf, refresh steps and the hand-off; a
//   request too large for the root for the root read and hand-off only.
//   The memory gives one row read and one row write per cycle; one item is in flight.
// Reset:
//   rst is synchronous. After it the block sweeps every memory row to zero,
//   one row per cycle, with in_ready low.
// Stall:
//   The output register holds a result until taken; the block keeps
//   accepting work while it waits, and holds a second result internally
//   (in_ready low) until the output register frees.
module first_fit_max_tree_allocator_core #(
  parameter int LEAVES     = 1024,
  parameter int VALUE_BITS = 30
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [ffmt_pkg::SLOT_W-1:0] slot_index,
  input  logic [ffmt_pkg::AMT_W-1:0]  amount,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found,
  output logic [ffmt_pkg::SLOT_W-1:0] chosen_slot
);
  import ffmt_pkg::*;

  localparam int ROW_W = $clog2(LEAVES);

  logic                    mem_we;
  logic [ROW_W-1:0]        mem_waddr;
  logic [2*VALUE_BITS-1:0] mem_wdata;
  logic [ROW_W-1:0]        mem_raddr;
  logic [2*VALUE_BITS-1:0] mem_rdata;
  logic                    res_valid;
  logic                    res_ready;
  ffmt_result_t            res;

  // Row r of the memory holds nodes 2r (low half) and 2r+1 (high half).
  ffmt_tree_ram #(
    .ROWS (LEAVES),
    .DW   (2 * VALUE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ffmt_walker #(
    .LEAVES     (LEAVES),
    .VALUE_BITS (VALUE_BITS)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .slot_index (slot_index),
    .amount     (amount),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Take a new result whenever the output register is empty or draining.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid   <= 1'b1;
      found       <= res.found;
      chosen_slot <= res.slot;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
